// ===== hdl/fxfr_pkg.sv =====
// fxfr_pkg: shared widths, codes and beat types of the fixed-point to fraction converter
// no dependencies; used by the interfaces, fxfr_mul, fxfr_core and the top level
package fxfr_pkg;

  localparam int FRAC_BITS = 32;
  localparam int INT_BITS  = 16;
  localparam int DEN_BITS  = 32;
  localparam int IN_W      = INT_BITS + FRAC_BITS;
  localparam int NUM_W     = INT_BITS + DEN_BITS + 1;
  localparam int PROD_W    = FRAC_BITS + DEN_BITS;
  localparam int TOL_W     = 16;
  localparam int STEP_W    = 20;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = (TOL_W > STEP_W) ? TOL_W : STEP_W;

  localparam logic [TOL_W-1:0]  TOL_RESET   = TOL_W'(4);
  localparam logic [STEP_W-1:0] STEPS_RESET = STEP_W'(65535);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOLERANCE = 1'b0,
    CFG_MAX_STEPS = 1'b1
  } fxfr_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CONVERGED  = 2'd0,
    ST_STEP_LIMIT = 2'd1,
    ST_DEN_OVF    = 2'd2
  } fxfr_status_t;

  typedef struct packed {
    logic [TOL_W-1:0]  tolerance;
    logic [STEP_W-1:0] max_steps;
  } fxfr_cfg_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] numerator;
    logic [DEN_BITS-1:0]     denominator;
    fxfr_status_t            status;
  } fxfr_res_t;

endpackage

// ===== hdl/fxfr_if.sv =====
// fxfr_if: valid/ready channels for the input and result beats
// depends on fxfr_pkg
interface fxfr_in_if import fxfr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface

interface fxfr_out_if import fxfr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] numerator;
  logic [DEN_BITS-1:0]     denominator;
  logic [1:0]              status;

  modport source (output valid, output numerator, output denominator, output status,
                  input ready);
  modport sink   (input valid, input numerator, input denominator, input status,
                  output ready);
endinterface

// ===== hdl/fxfr_mul.sv =====
// fxfr_mul: shared unsigned multiplier with a registered product
// depends on fxfr_pkg
module fxfr_mul import fxfr_pkg::*; (
  input  logic                  clk,
  input  logic [FRAC_BITS-1:0]  a,
  input  logic [DEN_BITS-1:0]   b,
  output logic [PROD_W-1:0]     p
);

  logic [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign p = p_r;

endmodule

// ===== hdl/fxfr_core.sv =====
// fxfr_core: sequencer and datapath of the mediant search
// depends on fxfr_pkg and fxfr_mul
module fxfr_core import fxfr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [IN_W-1:0] value_in,
  input  fxfr_cfg_t              cfg,
  output logic                   idle,
  output logic                   res_valid,
  input  logic                   res_ready,
  output fxfr_res_t              res
);

  typedef enum logic [2:0] {
    S_IDLE, S_MED, S_MUL_F, S_MUL_T, S_CMP, S_MUL_I, S_SUM, S_DONE
  } state_t;

  state_t              state_r;
  logic                neg_r;
  logic [INT_BITS-1:0] int_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [TOL_W-1:0]    tol_r;
  logic [STEP_W-1:0]   limit_r;
  logic [STEP_W-1:0]   step_r;
  logic [DEN_BITS-1:0] lo_num_r, lo_den_r, up_num_r, up_den_r;
  logic [DEN_BITS-1:0] mnum_r, mden_r;
  logic [PROD_W-1:0]   diff_r;
  logic                lt_r;
  logic [NUM_W-1:0]    mag_r;
  fxfr_status_t        status_r;

  logic                in_neg;
  logic [IN_W-1:0]     in_mag;
  logic [DEN_BITS:0]   nn, nd;
  logic [PROD_W-1:0]   lhs;
  logic [FRAC_BITS-1:0] mul_a;
  logic [PROD_W-1:0]   prod;

  assign in_neg = value_in[IN_W-1];
  assign in_mag = in_neg ? IN_W'(-value_in) : IN_W'(value_in);
  assign nn     = {1'b0, lo_num_r} + {1'b0, up_num_r};
  assign nd     = {1'b0, lo_den_r} + {1'b0, up_den_r};
  assign lhs    = {mnum_r, {FRAC_BITS{1'b0}}};

  // operand select for the shared multiplier
  always_comb begin
    case (state_r)
      S_MUL_T: mul_a = FRAC_BITS'(tol_r);
      S_MUL_I: mul_a = FRAC_BITS'(int_r);
      default: mul_a = frac_r;
    endcase
  end

  fxfr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mden_r),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= '0;
      status_r <= ST_CONVERGED;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            neg_r    <= in_neg;
            int_r    <= in_mag[IN_W-1:FRAC_BITS];
            frac_r   <= in_mag[FRAC_BITS-1:0];
            tol_r    <= cfg.tolerance;
            limit_r  <= (cfg.max_steps == '0) ? STEP_W'(1) : cfg.max_steps;
            lo_num_r <= '0;
            lo_den_r <= DEN_BITS'(1);
            up_num_r <= DEN_BITS'(1);
            up_den_r <= '0;
            step_r   <= '0;
            mnum_r   <= '0;
            mden_r   <= DEN_BITS'(1);
            status_r <= ST_CONVERGED;
            if (in_mag[FRAC_BITS-1:0] < FRAC_BITS'(cfg.tolerance)) begin
              state_r <= S_MUL_I;
            end else begin
              state_r <= S_MED;
            end
          end
        end
        S_MED: begin
          if (nn[DEN_BITS] || nd[DEN_BITS]) begin
            status_r <= ST_DEN_OVF;
            state_r  <= S_MUL_I;
          end else begin
            mnum_r  <= nn[DEN_BITS-1:0];
            mden_r  <= nd[DEN_BITS-1:0];
            step_r  <= step_r + STEP_W'(1);
            state_r <= S_MUL_F;
          end
        end
        S_MUL_F: begin
          state_r <= S_MUL_T;
        end
        S_MUL_T: begin
          // product holds frac * den here
          if (lhs < prod) begin
            lt_r   <= 1'b1;
            diff_r <= prod - lhs;
          end else begin
            lt_r   <= 1'b0;
            diff_r <= lhs - prod;
          end
          state_r <= S_CMP;
        end
        S_CMP: begin
          // product holds tolerance * den here
          if (diff_r < prod) begin
            status_r <= ST_CONVERGED;
            state_r  <= S_MUL_I;
          end else begin
            if (lt_r) begin
              lo_num_r <= mnum_r;
              lo_den_r <= mden_r;
            end else begin
              up_num_r <= mnum_r;
              up_den_r <= mden_r;
            end
            if (step_r >= limit_r) begin
              status_r <= ST_STEP_LIMIT;
              state_r  <= S_MUL_I;
            end else begin
              state_r <= S_MED;
            end
          end
        end
        S_MUL_I: begin
          state_r <= S_SUM;
        end
        S_SUM: begin
          mag_r   <= NUM_W'(prod) + NUM_W'(mnum_r);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign idle            = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_DONE);
  assign res.numerator   = $signed(neg_r ? (-mag_r) : mag_r);
  assign res.denominator = mden_r;
  assign res.status      = status_r;

`ifndef SYNTH
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (mden_r != '0))
    else $error("mediant denominator is zero during a search");

  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (step_r <= limit_r))
    else $error("step count passed the step limit");

  a_limit_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r == ST_STEP_LIMIT) |-> (step_r == limit_r))
    else $error("step limit status without reaching the limit");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !res_ready) |=> (state_r == S_DONE && $stable(mden_r)))
    else $error("result left before it was taken");
`endif

endmodule

// ===== hdl/fixed_to_fraction_mediant_search.sv =====
// fixed_to_fraction_mediant_search: top level, configuration registers and result register
// depends on fxfr_pkg, fxfr_if and fxfr_core
//
// Converts a signed Q16.32 value into a fraction numerator/denominator with a status code
// (converged, step limit reached, denominator overflow) by a Stern-Brocot mediant search.
// in_ch carries one value per beat; out_ch carries one result beat per input beat.
// cfg_we/cfg_index/cfg_wdata write the tolerance (index 0, in 2^-32 units) and the step
// limit (index 1); write them only while no conversion is in flight.
// in_ch.ready is high only while the search sequencer is idle; one value is worked at a time.
// Each mediant step passes through the mediant, two passes through the one shared 32x32
// multiplier and the compare; the search stops on convergence, at the step limit or at a
// mediant whose numerator or denominator overflows, after which the whole part is
// multiplied in and added. A fraction below the tolerance skips the search. The next value
// is taken in the cycle after the result enters the output register.
// The result sits in an output register; the sequencer goes idle again as soon as the
// register can take the result, so a new value is accepted while a result waits.
// When the receiver stalls with the register full, the sequencer holds its finished result.
// rst_n is synchronous: the tolerance returns to 4, the step limit to 65535, the
// sequencer to idle and the output register to empty.
module fixed_to_fraction_mediant_search import fxfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fxfr_in_if.sink               in_ch,
  fxfr_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [TOL_W-1:0]        tol_r;
  logic [STEP_W-1:0]       steps_r;
  logic                    out_valid_r;
  logic signed [NUM_W-1:0] out_num_r;
  logic [DEN_BITS-1:0]     out_den_r;
  logic [1:0]              out_status_r;

  fxfr_cfg_t cfg;
  fxfr_res_t res;
  logic      core_idle;
  logic      res_valid;
  logic      res_ready;

  assign cfg.tolerance = tol_r;
  assign cfg.max_steps = steps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= TOL_RESET;
      steps_r <= STEPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOLERANCE: tol_r   <= cfg_wdata[TOL_W-1:0];
        CFG_MAX_STEPS: steps_r <= cfg_wdata[STEP_W-1:0];
        default:       tol_r   <= tol_r;
      endcase
    end
  end

  assign in_ch.ready = core_idle;
  assign res_ready   = !out_valid_r || out_ch.ready;

  fxfr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_ch.valid && core_idle),
    .value_in  (in_ch.value_in),
    .cfg       (cfg),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r  <= 1'b1;
      out_num_r    <= res.numerator;
      out_den_r    <= res.denominator;
      out_status_r <= res.status;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.numerator   = out_num_r;
  assign out_ch.denominator = out_den_r;
  assign out_ch.status      = out_status_r;

endmodule

// ===== test/fxfr_fraction_checker.sv =====
// fxfr_fraction_checker: watches the value, result and register ports of the converter,
// predicts each fraction by its own mediant search and compares the result beats in order
// depends on fxfr_pkg and the channel interfaces in fxfr_if
module fxfr_fraction_checker import fxfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fxfr_in_if                    in_ch,
  fxfr_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    pending
);

  localparam logic [63:0] DEN_MAX = (64'd1 << DEN_BITS) - 64'd1;

  logic [TOL_W-1:0]  tolerance = TOL_RESET;
  logic [STEP_W-1:0] max_steps = STEPS_RESET;
  fxfr_res_t         awaited_fractions [$];

  function automatic fxfr_res_t mediant_fraction(input logic [IN_W-1:0] value,
                                                 input logic [TOL_W-1:0] tol,
                                                 input logic [STEP_W-1:0] steps);
    logic              neg;
    logic [IN_W-1:0]   mag;
    logic [63:0]       whole, frac, lo_n, lo_d, hi_n, hi_d, nn, nd, res_n, res_d, lim, total;
    logic [STEP_W-1:0] cnt;
    logic [127:0]      lhs, rhs, diff, bound;
    fxfr_status_t      st;
    fxfr_res_t         res;
    neg   = value[IN_W-1];
    mag   = neg ? -value : value;
    whole = 64'(mag >> FRAC_BITS);
    frac  = 64'(mag[FRAC_BITS-1:0]);
    lo_n  = 64'd0;
    lo_d  = 64'd1;
    hi_n  = 64'd1;
    hi_d  = 64'd0;
    res_n = 64'd0;
    res_d = 64'd1;
    cnt   = '0;
    st    = ST_CONVERGED;
    lim   = (steps == '0) ? 64'd1 : 64'(steps);
    // below the tolerance the answer is the whole part over one
    if (frac >= 64'(tol)) begin
      while (1'b1) begin
        nn = lo_n + hi_n;
        nd = lo_d + hi_d;
        if (nd > DEN_MAX || nn > DEN_MAX) begin
          st = ST_DEN_OVF;
          break;
        end
        res_n = nn;
        res_d = nd;
        cnt   = cnt + 1'b1;
        lhs   = 128'(nn) << FRAC_BITS;
        rhs   = 128'(frac) * 128'(nd);
        diff  = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
        bound = 128'(tol) * 128'(nd);
        if (diff < bound) begin
          st = ST_CONVERGED;
          break;
        end
        // an exact hit counts as above the target
        if (lhs < rhs) begin
          lo_n = nn;
          lo_d = nd;
        end else begin
          hi_n = nn;
          hi_d = nd;
        end
        if (64'(cnt) >= lim) begin
          st = ST_STEP_LIMIT;
          break;
        end
      end
    end
    total = whole * res_d + res_n;
    if (neg) total = -total;
    res.numerator   = total[NUM_W-1:0];
    res.denominator = res_d[DEN_BITS-1:0];
    res.status      = st;
    return res;
  endfunction

  task automatic report(input string why, input fxfr_res_t want, input fxfr_res_t got);
    if (mismatches < 10)
      $display("%0t %s: expected %0d/%0d status %0d, got %0d/%0d status %0d", $realtime, why,
               want.numerator, want.denominator, want.status,
               got.numerator, got.denominator, got.status);
    mismatches++;
  endtask

  always @(posedge clk) begin
    fxfr_res_t got, want;
    if (!rst_n) begin
      tolerance = TOL_RESET;
      max_steps = STEPS_RESET;
      awaited_fractions.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.numerator   = out_ch.numerator;
        got.denominator = out_ch.denominator;
        got.status      = fxfr_status_t'(out_ch.status);
        if (awaited_fractions.size() == 0) begin
          report("result beat with nothing awaited", '0, got);
        end else begin
          want = awaited_fractions.pop_front();
          if (got !== want) report("fraction mismatch", want, got);
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited_fractions.push_back(mediant_fraction(in_ch.value_in, tolerance, max_steps));
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOLERANCE: tolerance = cfg_wdata[TOL_W-1:0];
          CFG_MAX_STEPS: max_steps = cfg_wdata[STEP_W-1:0];
        endcase
      end
    end
    pending = awaited_fractions.size();
  end

endmodule

// ===== test/tb.sv =====
// tb: clock, reset, register writes and value beats for fixed_to_fraction_mediant_search,
// with random idling on both channels; the verdict comes from fxfr_fraction_checker
// depends on fxfr_pkg, fxfr_if, the converter and fxfr_fraction_checker
module tb;
  import fxfr_pkg::*;

  localparam int QUIET_LIMIT = 200000;
  localparam int HOLD_OFF    = 600;
  localparam int PHASE_ITEMS = 25;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  int                    hold_off_len = 0;
  int                    mismatches;
  int                    pending;
  int                    quiet;

  logic [IN_W-1:0] corner_values [10] = '{
    48'h0000_0000_0000,
    48'h8000_0000_0000,
    48'h7FFF_FFFF_FFFF,
    48'hFFFF_FFFF_FFFF,
    48'h0000_8000_0000,
    -{16'd3, 32'h4000_0000},
    {16'd7, 32'h5555_5555},
    {16'd1, 32'h9E37_79B9},
    {16'd3, 32'h243F_6A89},
    {16'd0, 32'h0000_0003}
  };

  fxfr_in_if  in_ch ();
  fxfr_out_if out_ch ();

  fixed_to_fraction_mediant_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fxfr_fraction_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [IN_W-1:0] rational_value(input logic [INT_BITS-1:0] whole,
                                                     input int unsigned p, input int unsigned q);
    logic [63:0] frac;
    frac = ((64'(p) << FRAC_BITS) + 64'(q / 2)) / 64'(q);
    return {whole, frac[FRAC_BITS-1:0]};
  endfunction

  // mostly raw bit patterns, some near small fractions, some with a fraction up to twice the tolerance plus one
  function automatic logic [IN_W-1:0] random_value(input logic [TOL_W-1:0] tol);
    int unsigned pick, q;
    logic [63:0] bits;
    pick = $urandom_range(9);
    bits = {$urandom, $urandom};
    q    = $urandom_range(2, 64);
    if (pick <= 5) return bits[IN_W-1:0];
    if (pick <= 8) return rational_value(bits[INT_BITS-1:0], $urandom_range(1, q - 1), q);
    return {bits[INT_BITS-1:0], 32'($urandom_range(0, 2 * int'(tol) + 1))};
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic put_value(input logic [IN_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.value_in <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_settings(input logic [TOL_W-1:0] tol, input logic [STEP_W-1:0] steps);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TOLERANCE;
    cfg_wdata <= CFG_DATA_W'(tol);
    @(negedge clk);
    cfg_index <= CFG_MAX_STEPS;
    cfg_wdata <= CFG_DATA_W'(steps);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver side
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_len) @(negedge clk);
        hold_off_len = 0;
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [TOL_W-1:0]  tol;
    logic [STEP_W-1:0] steps;
    in_ch.valid    = 1'b0;
    in_ch.value_in = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: extremes of the value and a few well known fractions
    foreach (corner_values[i]) put_value(corner_values[i]);
    drain();

    // zero tolerance: zero value, exact half, golden ratio running into overflow
    load_settings(16'd0, 20'd4096);
    put_value(48'h0000_0000_0000);
    put_value(48'h0000_8000_0000);
    put_value({16'd0, 32'h9E37_79B9});
    drain();

    // widest tolerance: fraction right at and just under it
    load_settings(16'hFFFF, 20'd8);
    put_value(-{16'd5, 32'h0000_FFFF});
    put_value({16'd9, 32'h0000_FFFE});
    put_value(48'h7FFF_FFFF_FFFF);
    drain();

    // single step, and a zero step limit
    load_settings(16'd100, 20'd1);
    put_value({16'd2, 32'h4CCC_CCCD});
    drain();
    load_settings(16'd100, 20'd0);
    put_value(-{16'd2, 32'h4CCC_CCCD});
    drain();

    load_settings(16'hFFFF, 20'hF_FFFF);
    put_value(rational_value(16'd3, 1, 7));
    put_value(rational_value(16'hFFFE, 5, 13));
    put_value(rational_value(16'd0, 31, 64));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          tol           = TOL_RESET;
          steps         = 20'd2048;
        end
        1: begin
          send_idle_pct = 87;
          stall_pct     = 0;
          tol           = TOL_W'($urandom_range(0, 65535));
          steps         = STEP_W'($urandom_range(1, 512));
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 87;
          tol           = 16'd1;
          steps         = 20'd1000;
        end
        default: begin
          send_idle_pct = 38;
          stall_pct     = 38;
          tol           = TOL_W'($urandom_range(0, 300));
          steps         = STEP_W'($urandom_range(1, 2048));
        end
      endcase
      load_settings(tol, steps);
      // long receiver hold-off so the converter fills and stalls its input
      if (ph == 3) hold_off_len = HOLD_OFF;
      repeat (PHASE_ITEMS) put_value(random_value(tol));
      drain();
    end

    repeat (32) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
